FILE: design/kmcd_pkg.sv
// Shared types and constants of the keypad matrix change detector.
`default_nettype none
package kmcd_pkg;

  localparam int ROW_W       = 3;
  localparam int COL_W       = 4;
  localparam int RAW_W       = 8;
  localparam int SCAN_W      = 7;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_SET_W   = 2 ** COL_W;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  localparam logic [CFG_W-1:0] RST_NUM_ROWS = 4'd8;
  localparam logic [CFG_W-1:0] RST_NUM_COLS = 4'd8;

  localparam logic [RAW_W-1:0] GROUND_BYTE = 8'hFF;

  // Hand-over of one row's work from the controller to the event emitter.
  typedef struct packed {
    logic                 load;
    logic [ROW_W-1:0]     row;
    logic [COL_SET_W-1:0] changed;
    logic [COL_SET_W-1:0] newset;
    logic                 ghost;
  } kmcd_cmd_t;

endpackage
`default_nettype wire

FILE: design/kmcd_if.sv
// Valid/ready channel interfaces for row scans and key events.
`default_nettype none
interface kmcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [kmcd_pkg::ROW_W-1:0]  row_index;
  logic [kmcd_pkg::RAW_W-1:0]  column_bits;
  logic                        scan_valid;

  modport source (output valid, row_index, column_bits, scan_valid, input ready);
  modport sink   (input valid, row_index, column_bits, scan_valid, output ready);
endinterface

interface kmcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [kmcd_pkg::ROW_W-1:0]  event_row;
  logic [kmcd_pkg::COL_W-1:0]  event_col;
  logic                        pressed;
  logic [kmcd_pkg::SCAN_W-1:0] scan_code;
  logic                        ghost;
  logic                        last;

  modport source (output valid, event_row, event_col, pressed, scan_code, ghost, last,
                  input ready);
  modport sink   (input valid, event_row, event_col, pressed, scan_code, ghost, last,
                  output ready);
endinterface
`default_nettype wire

FILE: design/kmcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kmcd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/kmcd_ctrl.sv
// Controller: configuration, row translation, ghost check and row state read-modify-write.
`default_nettype none
module kmcd_ctrl #(
  parameter int MAX_ROWS = kmcd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = kmcd_pkg::MAX_COLS_DEF,
  localparam int NC = MAX_COLS + 1,
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [kmcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kmcd_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [kmcd_pkg::ROW_W-1:0]     in_row_index,
  input  wire logic [kmcd_pkg::RAW_W-1:0]     in_column_bits,
  input  wire logic                           in_scan_valid,
  input  wire logic                           emit_busy,
  output kmcd_pkg::kmcd_cmd_t                 cmd,
  output logic                                mem_re,
  output logic      [AW-1:0]                  mem_raddr,
  output logic                                mem_we,
  output logic      [AW-1:0]                  mem_waddr,
  output logic      [NC-1:0]                  mem_wdata,
  input  wire logic [NC-1:0]                  mem_rdata
);

  localparam int RAW_EXT = (NC > kmcd_pkg::RAW_W) ? NC : kmcd_pkg::RAW_W;
  localparam int RW      = kmcd_pkg::CFG_W + 1;

  typedef enum logic {ST_IDLE, ST_CALC} state_t;

  state_t                         state_r, state_nxt;
  logic [kmcd_pkg::CFG_W-1:0]     num_rows_r, num_rows_nxt;
  logic [kmcd_pkg::CFG_W-1:0]     num_cols_r, num_cols_nxt;
  logic [NC-1:0]                  seen_r, seen_nxt;
  logic                           ghost_r, ghost_nxt;
  logic [MAX_ROWS-1:0]            written_r, written_nxt;
  logic [AW-1:0]                  addr_r, addr_nxt;
  logic [kmcd_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [NC-1:0]                  newset_r, newset_nxt;
  logic [kmcd_pkg::COL_W-1:0]     cols_r, cols_nxt;

  logic [RW-1:0]                  eff_rows;
  logic [kmcd_pkg::COL_W-1:0]     eff_cols;
  logic [RAW_EXT-1:0]             raw_ext;
  logic [NC-1:0]                  newset;
  logic [NC-1:0]                  seen_base;
  logic                           ghost_base;
  logic                           multi;
  logic                           accept;
  logic                           in_range;
  logic [NC-1:0]                  old_set;
  logic [NC-1:0]                  col_mask;

  always_comb begin
    eff_rows = ({1'b0, num_rows_r} > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : {1'b0, num_rows_r};
    eff_cols = (num_cols_r > kmcd_pkg::COL_W'(MAX_COLS)) ? kmcd_pkg::COL_W'(MAX_COLS)
                                                         : num_cols_r;
    raw_ext  = RAW_EXT'(in_column_bits);
    for (int j = 0; j < NC; j++) begin
      if (!in_scan_valid) begin
        newset[j] = 1'b0;
      end else if (in_column_bits == kmcd_pkg::GROUND_BYTE) begin
        newset[j] = (kmcd_pkg::COL_W'(j) == eff_cols);
      end else begin
        newset[j] = (kmcd_pkg::COL_W'(j) < eff_cols) && raw_ext[j];
      end
    end
    multi      = (newset & (newset - NC'(1))) != '0;
    in_ready   = (state_r == ST_IDLE) && !emit_busy;
    accept     = in_valid && in_ready;
    in_range   = RW'(in_row_index) < eff_rows;
    // A scan starting at row 0 restarts the ghost accumulation.
    seen_base  = (in_row_index == '0) ? '0 : seen_r;
    ghost_base = (in_row_index == '0) ? 1'b0 : ghost_r;

    for (int j = 0; j < NC; j++) begin
      col_mask[j] = kmcd_pkg::COL_W'(j) <= cols_r;
    end
    old_set = written_r[addr_r] ? mem_rdata : '0;
  end

  always_comb begin
    state_nxt    = state_r;
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    seen_nxt     = seen_r;
    ghost_nxt    = ghost_r;
    written_nxt  = written_r;
    addr_nxt     = addr_r;
    row_nxt      = row_r;
    newset_nxt   = newset_r;
    cols_nxt     = cols_r;

    if (cfg_we) begin
      case (cfg_index)
        kmcd_pkg::REG_NUM_ROWS: num_rows_nxt = cfg_wdata;
        kmcd_pkg::REG_NUM_COLS: num_cols_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && in_range) begin
          seen_nxt   = seen_base | newset;
          ghost_nxt  = ghost_base | (((newset & seen_base) != '0) && multi);
          addr_nxt   = AW'(in_row_index);
          row_nxt    = in_row_index;
          newset_nxt = newset;
          cols_nxt   = eff_cols;
          state_nxt  = ST_CALC;
        end
      end
      ST_CALC: begin
        written_nxt[addr_r] = 1'b1;
        state_nxt           = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      num_rows_r <= kmcd_pkg::RST_NUM_ROWS;
      num_cols_r <= kmcd_pkg::RST_NUM_COLS;
      seen_r     <= '0;
      ghost_r    <= 1'b0;
      written_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      num_rows_r <= num_rows_nxt;
      num_cols_r <= num_cols_nxt;
      seen_r     <= seen_nxt;
      ghost_r    <= ghost_nxt;
      written_r  <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    row_r    <= row_nxt;
    newset_r <= newset_nxt;
    cols_r   <= cols_nxt;
  end

  always_comb begin
    mem_re      = accept && in_range;
    mem_raddr   = AW'(in_row_index);
    mem_we      = (state_r == ST_CALC);
    mem_waddr   = addr_r;
    mem_wdata   = newset_r;
    cmd.load    = (state_r == ST_CALC);
    cmd.row     = row_r;
    cmd.changed = kmcd_pkg::COL_SET_W'((newset_r ^ old_set) & col_mask);
    cmd.newset  = kmcd_pkg::COL_SET_W'(newset_r);
    cmd.ghost   = ghost_r;
  end

endmodule
`default_nettype wire

FILE: design/kmcd_emit.sv
// Event emitter: walks the changed columns in ascending order into an output register.
`default_nettype none
module kmcd_emit #(
  parameter int MAX_COLS = kmcd_pkg::MAX_COLS_DEF,
  localparam int NC = MAX_COLS + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire kmcd_pkg::kmcd_cmd_t         cmd,
  output logic                             busy,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kmcd_pkg::ROW_W-1:0]       out_event_row,
  output logic [kmcd_pkg::COL_W-1:0]       out_event_col,
  output logic                             out_pressed,
  output logic [kmcd_pkg::SCAN_W-1:0]      out_scan_code,
  output logic                             out_ghost,
  output logic                             out_last
);

  logic [NC-1:0]                pending_r, pending_nxt;
  logic [NC-1:0]                newset_r, newset_nxt;
  logic [kmcd_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic                         ghost_r, ghost_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [kmcd_pkg::ROW_W-1:0]   ev_row_r;
  logic [kmcd_pkg::COL_W-1:0]   ev_col_r;
  logic                         pressed_r;
  logic                         ghost_out_r;
  logic                         last_r;

  logic [kmcd_pkg::COL_W-1:0]   idx;
  logic [NC-1:0]                pick;
  logic                         fire;

  always_comb begin
    idx = '0;
    for (int j = NC - 1; j >= 0; j--) begin
      if (pending_r[j]) begin
        idx = kmcd_pkg::COL_W'(j);
      end
    end
    pick = NC'(1) << idx;
    busy = pending_r != '0;
    fire = busy && (!out_valid_r || out_ready);

    pending_nxt   = pending_r;
    newset_nxt    = newset_r;
    row_nxt       = row_r;
    ghost_nxt     = ghost_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (cmd.load) begin
      pending_nxt = cmd.changed[NC-1:0];
      newset_nxt  = cmd.newset[NC-1:0];
      row_nxt     = cmd.row;
      ghost_nxt   = cmd.ghost;
    end else if (fire) begin
      pending_nxt   = pending_r & ~pick;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newset_r <= newset_nxt;
    row_r    <= row_nxt;
    ghost_r  <= ghost_nxt;
    if (fire) begin
      ev_row_r    <= row_r;
      ev_col_r    <= idx;
      pressed_r   <= newset_r[idx];
      ghost_out_r <= ghost_r;
      last_r      <= (pending_r & ~pick) == '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_row = ev_row_r;
  assign out_event_col = ev_col_r;
  assign out_pressed   = pressed_r;
  assign out_scan_code = {ev_row_r, ev_col_r};
  assign out_ghost     = ghost_out_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

FILE: design/keypad_matrix_change_detector.sv
// Top level of the keypad matrix change detector.
`default_nettype none
// Each input transaction carries one row scan of a key matrix (row number, raw column byte and
// a flag that either takes the byte or releases the whole row). The byte is turned into a
// column set, where the all-ones byte stands for a row tied to ground and maps to the extra
// column num_cols, and the set is compared with the state of that row held in a small RAM.
// Every changed column produces one output transaction, lowest column first, carrying the row,
// the column, the new key level, the scan code (row times sixteen plus column), the ghost flag
// of the scan so far and a last marker on the final event of the row. Rows at or above the
// configured row count are accepted and dropped without effect. A row goes through the RAM
// read and the write-back, then the emitter hands out one event per cycle while the output
// side does not stall, at most MAX_COLS plus one per row. The next row is taken as soon as
// the emitter has handed its last event to the output register, while that event may still
// wait there. The row RAM needs no clearing pass: a valid bit per row makes a row that was
// never written read as all keys released. Configuration is written through a plain write
// port and is only to be changed while the block is idle.
module keypad_matrix_change_detector #(
  parameter int MAX_ROWS = kmcd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = kmcd_pkg::MAX_COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [kmcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kmcd_pkg::CFG_W-1:0]     cfg_wdata,
  kmcd_in_if.sink                             in_ch,
  kmcd_out_if.source                          out_ch
);

  localparam int NC = MAX_COLS + 1;
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  kmcd_pkg::kmcd_cmd_t cmd;
  logic                emit_busy;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [NC-1:0]       mem_wdata;
  logic [NC-1:0]       mem_rdata;

  // Controller: holds the registers, translates the scan byte, keeps the ghost check and
  // performs the read-modify-write of the row state.
  kmcd_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_row_index   (in_ch.row_index),
    .in_column_bits (in_ch.column_bits),
    .in_scan_valid  (in_ch.scan_valid),
    .emit_busy      (emit_busy),
    .cmd            (cmd),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  // Row key state, one word per matrix row.
  kmcd_ram #(
    .WIDTH (NC),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Emitter: one event per changed column into the output register.
  kmcd_emit #(
    .MAX_COLS (MAX_COLS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .busy          (emit_busy),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_event_row (out_ch.event_row),
    .out_event_col (out_ch.event_col),
    .out_pressed   (out_ch.pressed),
    .out_scan_code (out_ch.scan_code),
    .out_ghost     (out_ch.ghost),
    .out_last      (out_ch.last)
  );

endmodule
`default_nettype wire
